>>> sv/apdu_ser_pkg.sv
// shared types and codes for the apdu command serializer
package apdu_ser_pkg;

	localparam logic REQ_HEADER = 1'b0;
	localparam logic REQ_DATA   = 1'b1;

	localparam logic [2:0] CASE_1       = 3'd0;
	localparam logic [2:0] CASE_2_SHORT = 3'd1;
	localparam logic [2:0] CASE_2_EXT   = 3'd2;
	localparam logic [2:0] CASE_3_SHORT = 3'd3;
	localparam logic [2:0] CASE_3_EXT   = 3'd4;
	localparam logic [2:0] CASE_4_SHORT = 3'd5;
	localparam logic [2:0] CASE_4_EXT   = 3'd6;
	localparam logic [2:0] CASE_INVALID = 3'd7;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_CASE   = 2'd1;
	localparam logic [1:0] ST_LC_T0      = 2'd2;
	localparam logic [1:0] ST_UNEXPECTED = 2'd3;

	localparam int unsigned MAX_BYTES = 7;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [15:0] LC_SHORT_MAX = 16'd255;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  class_byte;
		logic [7:0]  instr_byte;
		logic [7:0]  param_one;
		logic [7:0]  param_two;
		logic [2:0]  apdu_case;
		logic [15:0] data_count;
		logic [16:0] expected_len;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic [1:0]      n;
		logic [1:0][7:0] b;
	} trailer_t;

	// le trailer after the data bytes of a t1 command that has both data and response
	function automatic trailer_t le_trailer(logic t0, logic [2:0] cs, logic [15:0] le);
		trailer_t r;
		r = '0;
		if (!t0) begin
			if (cs == CASE_4_SHORT) begin
				r.n = 2'd1;
				r.b[0] = le[7:0];
			end else if (cs == CASE_4_EXT) begin
				r.n = 2'd2;
				r.b[0] = le[15:8];
				r.b[1] = le[7:0];
			end
		end
		return r;
	endfunction

endpackage

>>> sv/apdu_command_serializer_core.sv
// apdu command serializer top level
//
// A header beat on in_data starts a command; the block queues its header and
// length bytes (four to seven in all) in a result buffer and sends them on
// out_data one beat per cycle while out_ready is high. Each following data
// beat passes one command byte, plus the Le trailer after the last one.
// last_byte marks the final byte of a command and every error result.
// Latency: the first result of an item is valid in the cycle after it is
// accepted. Data streams at one byte per cycle while out_ready is high; the
// last data beat also carries the Le trailer, up to three bytes in all.
// A header beat holds the input until all its bytes, up to seven, are taken,
// since the single result buffer drains one byte per cycle while out_ready is high.
// in_ready rises in the cycle the buffer's last byte is taken, so the next
// item is loaded with no gap.
// When the receiver stalls, the buffer holds and in_ready stays low.
// The cfg channel writes protocol_t0 (1 = T0 layout); it is always ready.
// Reset empties the buffer and clears the command state and protocol_t0 (T1 layout).
module apdu_command_serializer_core
	import apdu_ser_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	logic        protocol_t0_q;
	logic [15:0] bytes_left_q;
	logic [2:0]  held_case_q;
	logic [15:0] held_expected_q;
	logic        in_command_q;

	logic [7:0]  seq_q [MAX_BYTES];
	logic [2:0]  cnt_q;
	logic        last_q;
	logic [1:0]  st_q;

	logic [7:0]  seq_d [MAX_BYTES];
	logic [7:0]  pre [MAX_BYTES];
	logic [2:0]  npre;
	logic [2:0]  cnt_d;
	logic        last_d;
	logic [1:0]  st_d;
	logic [15:0] bl_d;
	logic        inc_d;
	logic        hold_upd;
	trailer_t    trl;

	logic in_acc;
	logic out_acc;

	assign cfg_ready = 1'b1;
	assign out_valid = (cnt_q != 3'd0);
	assign out_acc   = out_valid && out_ready;
	assign in_ready  = (cnt_q == 3'd0) || (out_ready && cnt_q == 3'd1);
	assign in_acc    = in_valid && in_ready;

	assign out_data.out_byte  = seq_q[0];
	assign out_data.last_byte = last_q && (cnt_q == 3'd1);
	assign out_data.status    = st_q;

	always_comb begin
		logic [2:0]  cs;
		logic [15:0] lc;
		logic [15:0] le;
		logic        err;
		logic        trl_done;
		logic [2:0]  idx;
		cs       = in_data.apdu_case;
		lc       = in_data.data_count;
		le       = in_data.expected_len[15:0];
		err      = 1'b0;
		trl_done = 1'b0;
		st_d     = ST_OK;
		last_d   = 1'b0;
		bl_d     = bytes_left_q;
		inc_d    = in_command_q;
		hold_upd = 1'b0;
		trl      = '0;
		npre     = 3'd0;
		idx      = 3'd0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			pre[i] = BYTE_ZERO;
		end
		if (in_data.req_type == REQ_HEADER) begin
			pre[0] = in_data.class_byte;
			pre[1] = in_data.instr_byte;
			pre[2] = in_data.param_one;
			pre[3] = in_data.param_two;
			npre   = 3'd4;
			if (cs == CASE_INVALID) begin
				err  = 1'b1;
				st_d = ST_BAD_CASE;
			end else if (cs == CASE_3_EXT && protocol_t0_q && lc > LC_SHORT_MAX) begin
				err  = 1'b1;
				st_d = ST_LC_T0;
			end else begin
				case (cs) inside
					CASE_1: begin
						if (protocol_t0_q) begin
							pre[4] = BYTE_ZERO;
							npre   = 3'd5;
						end
					end
					CASE_2_SHORT: begin
						pre[4] = le[7:0];
						npre   = 3'd5;
					end
					CASE_2_EXT: begin
						if (protocol_t0_q) begin
							pre[4] = le[7:0];
							npre   = 3'd5;
						end else begin
							pre[4] = BYTE_ZERO;
							pre[5] = le[15:8];
							pre[6] = le[7:0];
							npre   = 3'd7;
						end
					end
					CASE_3_SHORT, CASE_4_SHORT: begin
						pre[4] = lc[7:0];
						npre   = 3'd5;
					end
					default: begin
						if (protocol_t0_q) begin
							pre[4] = lc[7:0];
							npre   = 3'd5;
						end else if (cs == CASE_4_EXT && lc == 16'd0) begin
							// no data bytes: only le goes out, in extended form
							pre[4]   = BYTE_ZERO;
							pre[5]   = le[15:8];
							pre[6]   = le[7:0];
							npre     = 3'd7;
							trl_done = 1'b1;
						end else begin
							pre[4] = BYTE_ZERO;
							pre[5] = lc[15:8];
							pre[6] = lc[7:0];
							npre   = 3'd7;
						end
					end
				endcase
				hold_upd = 1'b1;
				bl_d     = (cs >= CASE_3_SHORT) ? lc : 16'd0;
				if (bl_d == 16'd0) begin
					if (!trl_done) begin
						trl = le_trailer(protocol_t0_q, cs, le);
					end
					last_d = 1'b1;
					inc_d  = 1'b0;
				end else begin
					inc_d = 1'b1;
				end
			end
			if (err) begin
				bl_d  = 16'd0;
				inc_d = 1'b0;
			end
		end else begin
			if (!in_command_q || bytes_left_q == 16'd0) begin
				err  = 1'b1;
				st_d = ST_UNEXPECTED;
			end else begin
				pre[0] = in_data.data_byte;
				npre   = 3'd1;
				bl_d   = bytes_left_q - 16'd1;
				if (bl_d == 16'd0) begin
					trl    = le_trailer(protocol_t0_q, held_case_q, held_expected_q);
					last_d = 1'b1;
					inc_d  = 1'b0;
				end
			end
		end
		if (err) begin
			for (int i = 0; i < MAX_BYTES; i++) begin
				seq_d[i] = BYTE_ZERO;
			end
			cnt_d  = 3'd1;
			last_d = 1'b1;
		end else begin
			for (int i = 0; i < MAX_BYTES; i++) begin
				idx      = 3'(i) - npre;
				seq_d[i] = (3'(i) < npre) ? pre[i] : trl.b[idx[0]];
			end
			cnt_d = npre + {1'b0, trl.n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_t0_q   <= 1'b0;
			bytes_left_q    <= '0;
			held_case_q     <= CASE_1;
			held_expected_q <= '0;
			in_command_q    <= 1'b0;
			cnt_q           <= '0;
			last_q          <= 1'b0;
			st_q            <= ST_OK;
		end else begin
			if (cfg_valid && cfg_ready) begin
				protocol_t0_q <= cfg_data;
			end
			if (in_acc) begin
				cnt_q        <= cnt_d;
				last_q       <= last_d;
				st_q         <= st_d;
				bytes_left_q <= bl_d;
				in_command_q <= inc_d;
				if (hold_upd) begin
					held_case_q     <= in_data.apdu_case;
					held_expected_q <= in_data.expected_len[15:0];
				end
			end else if (out_acc) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	// byte buffer, drained from the front
	always_ff @(posedge clk) begin
		if (in_acc) begin
			seq_q <= seq_d;
		end else if (out_acc) begin
			for (int i = 0; i < MAX_BYTES - 1; i++) begin
				seq_q[i] <= seq_q[i + 1];
			end
		end
	end

`ifndef SYNTHESIS
	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted beat produced no result");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.last_byte && cnt_q == 3'd1)
		else $error("error result not a single last beat");

	a_busy_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		in_command_q |-> bytes_left_q != 16'd0)
		else $error("command open with no data bytes left");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && out_valid |-> out_ready && cnt_q == 3'd1)
		else $error("buffer reloaded before it drained");
`endif

endmodule
